[hdl/rpy_homogeneous_transform_macros.svh]
// assertion helpers shared by the checker
`ifndef RPY_HOMOGENEOUS_TRANSFORM_MACROS_SVH
`define RPY_HOMOGENEOUS_TRANSFORM_MACROS_SVH

// checked only outside reset
`define RPY_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rpy check failed");

// checked also while reset is high
`define RPY_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rpy reset check failed");

`endif

[hdl/rpy_pkg.sv]
package rpy_pkg;

  localparam int QI      = 30;
  localparam int SIN_LAT = 9;
  localparam int ROT_W   = 18;
  localparam int POS_W   = 24;
  localparam int OUT_W   = 240;

  // q30 coefficients of sin(pi/2*u), index 0 is the linear term
  localparam logic [31:0] SIN_COEF [7] = '{
    32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026996,
    32'd172272, 32'd3864, 32'd61
  };

  // q30 product, magnitude rounded half away from zero
  function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] pr;
    logic [31:0] m;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    pr = ma * mb + (64'd1 << (QI - 1));
    m  = pr[61:30];
    return (a[31] ^ b[31]) ? -$signed(m) : $signed(m);
  endfunction

endpackage

[hdl/rpy_sine.sv]
module rpy_sine
  import rpy_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [31:0] sin_q
);

  logic [30:0] u0;
  logic [30:0] u_s [1:8];
  logic        n_s [1:8];
  logic [30:0] w_s [2:7];
  logic [31:0] p_s [3:8];
  logic [31:0] pin [3:8];
  logic [31:0] p_next [3:8];
  logic [61:0] uu;
  logic [63:0] fin;
  logic [33:0] s9;
  logic [31:0] s_clamp;

  // odd quadrants run the quarter wave backwards
  assign u0 = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
  assign uu = u_s[1] * u_s[1];

  always_comb begin
    logic [62:0] pw;
    pin[3] = SIN_COEF[6];
    for (int s = 4; s <= 8; s++) pin[s] = p_s[s-1];
    for (int s = 3; s <= 8; s++) begin
      pw = pin[s] * w_s[s-1];
      p_next[s] = SIN_COEF[8-s] - pw[61:30];
    end
  end

  assign fin     = p_s[8] * u_s[8];
  assign s9      = fin[63:30];
  assign s_clamp = (s9 > 34'h4000_0000) ? 32'h4000_0000 : s9[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      u_s[1] <= u0;
      n_s[1] <= phase[31];
      w_s[2] <= uu[60:30];
      for (int s = 2; s <= 8; s++) begin
        u_s[s] <= u_s[s-1];
        n_s[s] <= n_s[s-1];
      end
      for (int s = 3; s <= 7; s++) w_s[s] <= w_s[s-1];
      for (int s = 3; s <= 8; s++) p_s[s] <= p_next[s];
      sin_q <= n_s[8] ? -$signed(s_clamp) : $signed(s_clamp);
    end
  end

endmodule

[hdl/rpy_homogeneous_transform.sv]
// Roll-pitch-yaw pose to homogeneous transform. Each beat carries a translation
// and three binary angles and yields the top three rows of the pose matrix: the
// ZYX rotation Rz*Ry*Rx as nine Q1.FRAC_BITS entries plus the translation
// passed through. A beat is taken every cycle unless the output holds a result; the
// pipeline is the sine units (9 stages each, evaluating the polynomial), two
// product stages, a sum stage and the output rounding stage. A held result on
// the output freezes the whole pipeline until it is taken.
module rpy_homogeneous_transform
  import rpy_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // shift_x, shift_y, shift_z, roll, pitch, yaw, zero fill
  input  logic [((72 + 3*ANGLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // rot_00..rot_22 row by row, trans_x, trans_y, trans_z, zero fill
  output logic [OUT_W-1:0]    m_axis_tdata
);

  localparam int LAT = SIN_LAT + 4;
  localparam int SH  = QI - FRAC_BITS;
  localparam logic [33:0] RND = (34'd1 << SH) >> 1;
  localparam logic [33:0] LIM = 34'd1 << FRAC_BITS;

  logic en;
  logic vld [LAT];
  logic [POS_W-1:0] tx [LAT];
  logic [POS_W-1:0] ty [LAT];
  logic [POS_W-1:0] tz [LAT];

  logic [31:0] ph [6];
  logic signed [31:0] sv [6];

  logic signed [31:0] czsy, szsy, czcy, szcy, szcx, szsx, czcx, czsx, cysx, cycx;
  logic signed [31:0] sx2, cx2, nsy2;
  logic signed [31:0] t1, t2, t3, t4;
  logic signed [31:0] szcx3, szsx3, czcx3, czsx3, czcy3, szcy3, cysx3, cycx3, nsy3;
  logic signed [32:0] e [9];
  logic [ROT_W-1:0] rot [9];
  logic [ROT_W-1:0] rot_next [9];

  assign en            = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  // angle to 32-bit phase, sine then cosine for roll, pitch, yaw
  always_comb begin
    logic [31:0] a;
    for (int i = 0; i < 3; i++) begin
      a = {s_axis_tdata[72 + i*ANGLE_BITS +: ANGLE_BITS], {(32 - ANGLE_BITS){1'b0}}};
      ph[2*i]   = a;
      ph[2*i+1] = a + 32'h4000_0000;
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_sin
    rpy_sine u_sine (.clk(clk), .en(en), .phase(ph[g]), .sin_q(sv[g]));
  end

  // sv: 0 sx, 1 cx, 2 sy, 3 cy, 4 sz, 5 cz
  always_ff @(posedge clk) begin
    if (en) begin
      czsy <= mul_q(sv[5], sv[2]);
      szsy <= mul_q(sv[4], sv[2]);
      czcy <= mul_q(sv[5], sv[3]);
      szcy <= mul_q(sv[4], sv[3]);
      szcx <= mul_q(sv[4], sv[1]);
      szsx <= mul_q(sv[4], sv[0]);
      czcx <= mul_q(sv[5], sv[1]);
      czsx <= mul_q(sv[5], sv[0]);
      cysx <= mul_q(sv[3], sv[0]);
      cycx <= mul_q(sv[3], sv[1]);
      sx2  <= sv[0];
      cx2  <= sv[1];
      nsy2 <= -sv[2];

      t1 <= mul_q(czsy, sx2);
      t2 <= mul_q(czsy, cx2);
      t3 <= mul_q(szsy, sx2);
      t4 <= mul_q(szsy, cx2);
      szcx3 <= szcx;
      szsx3 <= szsx;
      czcx3 <= czcx;
      czsx3 <= czsx;
      czcy3 <= czcy;
      szcy3 <= szcy;
      cysx3 <= cysx;
      cycx3 <= cycx;
      nsy3  <= nsy2;

      e[0] <= 33'(czcy3);
      e[1] <= 33'(t1) - 33'(szcx3);
      e[2] <= 33'(t2) + 33'(szsx3);
      e[3] <= 33'(szcy3);
      e[4] <= 33'(t3) + 33'(czcx3);
      e[5] <= 33'(t4) - 33'(czsx3);
      e[6] <= 33'(nsy3);
      e[7] <= 33'(cysx3);
      e[8] <= 33'(cycx3);

      for (int i = 0; i < 9; i++) rot[i] <= rot_next[i];
    end
  end

  // q30 to output scale: round magnitude, saturate, sign last
  always_comb begin
    logic [32:0] mag;
    logic [33:0] r;
    logic [33:0] v;
    for (int i = 0; i < 9; i++) begin
      mag = e[i][32] ? 33'(-e[i]) : 33'(e[i]);
      r   = ({1'b0, mag} + RND) >> SH;
      if (r > LIM) r = LIM;
      v   = e[i][32] ? -r : r;
      rot_next[i] = v[ROT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx[0] <= s_axis_tdata[23:0];
      ty[0] <= s_axis_tdata[47:24];
      tz[0] <= s_axis_tdata[71:48];
      for (int i = 1; i < LAT; i++) begin
        tx[i] <= tx[i-1];
        ty[i] <= ty[i-1];
        tz[i] <= tz[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 9; i++) m_axis_tdata[i*ROT_W +: ROT_W] = rot[i];
    m_axis_tdata[162 +: POS_W] = tx[LAT-1];
    m_axis_tdata[186 +: POS_W] = ty[LAT-1];
    m_axis_tdata[210 +: POS_W] = tz[LAT-1];
  end

endmodule

[hdl/rpy_checker.sv]
`include "rpy_homogeneous_transform_macros.svh"

module rpy_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  `RPY_ASSERT_RST(a_reset_empty, rst |=> !m_axis_tvalid)
  `RPY_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `RPY_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready)
  `RPY_ASSERT(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)

endmodule

bind rpy_homogeneous_transform rpy_checker u_rpy_checker (
  .clk(clk),
  .rst(rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);
